### rtl/configurable_crc_engine_assert.svh
// Assertion macros for the CRC engine RTL.
// Used by modules that check their own logic; expects clk and rst in scope.
`ifndef CONFIGURABLE_CRC_ENGINE_ASSERT_SVH
`define CONFIGURABLE_CRC_ENGINE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define CCE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cce_pkg.sv
// Shared types, constants and helper functions for the CRC engine.
// No dependencies; imported by every module of the engine but cce_out.
package cce_pkg;

  localparam logic [31:0] CRC_POLY_RESET = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_ONES32     = 32'hFFFF_FFFF;

  localparam logic [1:0] WIDTH_MODE_8  = 2'd0;
  localparam logic [1:0] WIDTH_MODE_16 = 2'd1;
  localparam logic [1:0] WIDTH_MODE_32 = 2'd2;

  localparam logic [2:0] REG_WIDTH_MODE  = 3'd0;
  localparam logic [2:0] REG_POLY        = 3'd1;
  localparam logic [2:0] REG_INIT_VALUE  = 3'd2;
  localparam logic [2:0] REG_XOR_OUT     = 3'd3;
  localparam logic [2:0] REG_REFLECT_IN  = 3'd4;
  localparam logic [2:0] REG_REFLECT_OUT = 3'd5;

  typedef struct packed {
    logic [1:0]  width_mode;
    logic [31:0] poly;
    logic [31:0] init_value;
    logic [31:0] xor_out;
    logic        reflect_in;
    logic        reflect_out;
  } cce_cfg_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] value;
  } cce_reload_t;

  function automatic logic [31:0] width_mask(input logic [1:0] mode);
    logic [31:0] m;
    unique case (mode)
      WIDTH_MODE_8:  m = 32'h0000_00FF;
      WIDTH_MODE_16: m = 32'h0000_FFFF;
      default:       m = CRC_ONES32;
    endcase
    return m;
  endfunction

  // Bit-reverse the low W bits, W chosen by the width code.
  function automatic logic [31:0] reflect_w(input logic [31:0] v, input logic [1:0] mode);
    logic [31:0] rev;
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      rev[i] = v[31-i];
    end
    unique case (mode)
      WIDTH_MODE_8:  r = {24'd0, rev[31:24]};
      WIDTH_MODE_16: r = {16'd0, rev[31:16]};
      default:       r = rev;
    endcase
    return r;
  endfunction

endpackage

### rtl/cce_cfg.sv
// Configuration register file of the CRC engine.
// Depends on cce_pkg; raises a reload of the CRC register on every valid write.
module cce_cfg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  output cce_pkg::cce_cfg_t    cfg,
  output cce_pkg::cce_reload_t reload
);
  import cce_pkg::*;

  cce_cfg_t cfg_next;
  logic     hit;

  always_comb begin
    cfg_next = cfg;
    hit      = 1'b0;
    if (cfg_write_en) begin
      hit = 1'b1;
      unique case (cfg_index)
        REG_WIDTH_MODE:  cfg_next.width_mode  = cfg_data[1:0];
        REG_POLY:        cfg_next.poly        = cfg_data;
        REG_INIT_VALUE:  cfg_next.init_value  = cfg_data;
        REG_XOR_OUT:     cfg_next.xor_out     = cfg_data;
        REG_REFLECT_IN:  cfg_next.reflect_in  = cfg_data[0];
        REG_REFLECT_OUT: cfg_next.reflect_out = cfg_data[0];
        default:         hit = 1'b0;
      endcase
    end
  end

  assign reload.valid = hit;
  assign reload.value = cfg_next.init_value & width_mask(cfg_next.width_mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_mode  <= WIDTH_MODE_32;
      cfg.poly        <= CRC_POLY_RESET;
      cfg.init_value  <= CRC_ONES32;
      cfg.xor_out     <= CRC_ONES32;
      cfg.reflect_in  <= 1'b1;
      cfg.reflect_out <= 1'b1;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

### rtl/cce_step.sv
// Byte update network of the CRC engine: eight unrolled shift/XOR steps
// and the output finish (reflect, xor, mask). Depends on cce_pkg.
module cce_step (
  input  cce_pkg::cce_cfg_t cfg,
  input  logic [31:0]       crc,
  input  logic [7:0]        data_byte,
  output logic [31:0]       crc_next,
  output logic [31:0]       crc_final
);
  import cce_pkg::*;

  logic [31:0] m;
  logic [31:0] p;
  logic [31:0] rp;
  logic [31:0] top;
  logic [31:0] c;
  logic [31:0] r;
  logic        fb;

  always_comb begin
    m   = width_mask(cfg.width_mode);
    p   = cfg.poly & m;
    rp  = reflect_w(p, cfg.width_mode);
    top = m ^ (m >> 1);
    c   = crc & m;
    fb  = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (cfg.reflect_in) begin
        fb = c[0] ^ data_byte[i];
        c  = fb ? ((c >> 1) ^ rp) : (c >> 1);
      end else begin
        fb = (|(c & top)) ^ data_byte[7-i];
        c  = (c << 1) & m;
        if (fb) begin
          c = c ^ p;
        end
      end
    end
    crc_next = c;
    r = (cfg.reflect_out != cfg.reflect_in) ? reflect_w(c, cfg.width_mode) : c;
    crc_final = (r ^ cfg.xor_out) & m;
  end

endmodule

### rtl/cce_out.sv
// Result register of the CRC engine with valid/ready handshake.
// No package dependency; holds one finished CRC until taken.
module cce_out (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic [31:0] value,
  output logic        free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] crc_value
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      crc_value <= value;
    end
  end

endmodule

### rtl/configurable_crc_engine.sv
// Top level of the configurable 8/16/32-bit CRC engine.
// Depends on cce_pkg, cce_cfg, cce_step, cce_out and the assertion header.
//
//   channel  direction  signals
//   in       slave      in_valid, in_ready, data_byte, last_byte
//   out      master     out_valid, out_ready, crc_value
//   cfg      write      cfg_write_en, cfg_index, cfg_data
//
// One byte per cycle while no last byte waits on a stalled result; the crc register
// loop through the 8-step XOR network sets it. The result is registered in cce_out.
// Reset is synchronous; it restores default config and the crc register.
// A stalled result holds up the next last byte and the bytes behind it only.
`include "configurable_crc_engine_assert.svh"
module configurable_crc_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] crc_value,
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import cce_pkg::*;

  cce_cfg_t    cfg;
  cce_reload_t reload;

  logic        s1_valid;
  logic [7:0]  s1_data;
  logic        s1_last;
  logic        step_fire;
  logic        out_free;
  logic [31:0] crc_reg;
  logic [31:0] crc_reg_next;
  logic [31:0] step_crc;
  logic [31:0] step_final;

  cce_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg),
    .reload       (reload)
  );

  cce_step u_step (
    .cfg       (cfg),
    .crc       (crc_reg),
    .data_byte (s1_data),
    .crc_next  (step_crc),
    .crc_final (step_final)
  );

  cce_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step_fire && s1_last),
    .value     (step_final),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .crc_value (crc_value)
  );

  assign step_fire = s1_valid && (!s1_last || out_free);
  assign in_ready  = !s1_valid || step_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= data_byte;
      s1_last <= last_byte;
    end
  end

  always_comb begin
    priority if (reload.valid) begin
      crc_reg_next = reload.value;
    end else if (step_fire) begin
      crc_reg_next = s1_last ? (cfg.init_value & width_mask(cfg.width_mode)) : step_crc;
    end else begin
      crc_reg_next = crc_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg <= CRC_ONES32;
    end else begin
      crc_reg <= crc_reg_next;
    end
  end

  `CCE_ASSERT_NEXT(a_last_gives_result, step_fire && s1_last, out_valid,
    "last item did not produce a result")
  `CCE_ASSERT_NEXT(a_reload_after_last, step_fire && s1_last,
    crc_reg == (cfg.init_value & width_mask(cfg.width_mode)),
    "crc register not reloaded after last item")
  `CCE_ASSERT_SAME(a_stall_cause, s1_valid && !in_ready,
    s1_last && out_valid && !out_ready,
    "input stalled without a blocked result")
  `CCE_ASSERT_NEXT(a_width8_clean, step_fire && s1_last && cfg.width_mode == WIDTH_MODE_8,
    crc_value[31:8] == 24'd0,
    "8-bit result has bits set above the width")

endmodule

### verif/tb_configurable_crc_engine.sv
`timescale 1ns / 100ps
// Self-checking testbench for configurable_crc_engine: random byte messages under
// many CRC settings, checked against an in-bench CRC predictor. Needs cce_pkg.
module tb_configurable_crc_engine;
  import cce_pkg::*;

  localparam logic [1:0] WIDTH_MODE_SPARE = 2'd3;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int TOTAL_BYTES = 1950;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] crc_value;
  logic        cfg_write_en = 1'b0;
  logic [2:0]  cfg_index = REG_WIDTH_MODE;
  logic [31:0] cfg_data = 32'h0;

  msg_byte_t   byte_stream[$];
  logic [31:0] pending_crcs[$];
  cce_cfg_t    shadow_cfg;
  logic [31:0] shadow_crc;
  logic        in_took = 1'b0;
  int          in_gap = 0;
  int          stall_left = 0;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  int          bytes_queued = 0;
  int          mismatches = 0;
  int          cycle_count = 0;

  configurable_crc_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_ready(out_ready), .crc_value(crc_value),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int crc_bits(input logic [1:0] mode);
    if (mode == WIDTH_MODE_8) return 8;
    if (mode == WIDTH_MODE_16) return 16;
    return 32;
  endfunction

  function automatic logic [31:0] crc_mask_of(input int w);
    return (w >= 32) ? CRC_ONES32 : ((32'h1 << w) - 32'h1);
  endfunction

  function automatic logic [31:0] mirror_bits(input logic [31:0] v, input int w);
    logic [31:0] r;
    int i;
    r = 32'h0;
    for (i = 0; i < w; i++) begin
      r = {r[30:0], v[0]};
      v = v >> 1;
    end
    return r;
  endfunction

  function automatic void reload_crc();
    shadow_crc = shadow_cfg.init_value & crc_mask_of(crc_bits(shadow_cfg.width_mode));
  endfunction

  function automatic void apply_cfg_write(input logic [2:0] idx, input logic [31:0] v);
    logic known;
    known = 1'b1;
    case (idx)
      REG_WIDTH_MODE:  shadow_cfg.width_mode = v[1:0];
      REG_POLY:        shadow_cfg.poly = v;
      REG_INIT_VALUE:  shadow_cfg.init_value = v;
      REG_XOR_OUT:     shadow_cfg.xor_out = v;
      REG_REFLECT_IN:  shadow_cfg.reflect_in = v[0];
      REG_REFLECT_OUT: shadow_cfg.reflect_out = v[0];
      default:         known = 1'b0;
    endcase
    if (known) reload_crc();
  endfunction

  function automatic void crc_absorb(input logic [7:0] b, input logic lst);
    int          w;
    int          i;
    logic [31:0] m;
    logic [31:0] p;
    logic [31:0] rp;
    logic [31:0] c;
    logic [31:0] top;
    logic [31:0] r;
    logic [7:0]  d;
    logic        fb;
    w = crc_bits(shadow_cfg.width_mode);
    m = crc_mask_of(w);
    p = shadow_cfg.poly & m;
    c = shadow_crc & m;
    top = 32'h1 << (w - 1);
    d = b;
    if (shadow_cfg.reflect_in) begin
      rp = mirror_bits(p, w);
      for (i = 0; i < 8; i++) begin
        if (c[0] ^ d[0]) c = (c >> 1) ^ rp;
        else c = c >> 1;
        d = d >> 1;
      end
    end else begin
      for (i = 0; i < 8; i++) begin
        fb = ((c & top) != 32'h0) ^ d[7];
        c = (c << 1) & m;
        if (fb) c = c ^ p;
        d = d << 1;
      end
    end
    shadow_crc = c & m;
    if (lst) begin
      r = shadow_crc;
      if (shadow_cfg.reflect_out != shadow_cfg.reflect_in) r = mirror_bits(r, w);
      pending_crcs.push_back((r ^ shadow_cfg.xor_out) & m);
      reload_crc();
    end
  endfunction

  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return CRC_ONES32;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %08h, expected %08h (cycle %0d)", what, got, want, cycle_count);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    logic [31:0] want;
    if (rst) begin
      shadow_cfg.width_mode = WIDTH_MODE_32;
      shadow_cfg.poly = CRC_POLY_RESET;
      shadow_cfg.init_value = CRC_ONES32;
      shadow_cfg.xor_out = CRC_ONES32;
      shadow_cfg.reflect_in = 1'b1;
      shadow_cfg.reflect_out = 1'b1;
      reload_crc();
      in_took <= 1'b0;
    end else begin
      if (cfg_write_en) apply_cfg_write(cfg_index, cfg_data);
      if (in_valid && in_ready) crc_absorb(data_byte, last_byte);
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (pending_crcs.size() == 0) begin
          report_mismatch("unexpected crc_value", crc_value, 32'h0);
        end else begin
          want = pending_crcs.pop_front();
          if (crc_value !== want) report_mismatch("crc_value", crc_value, want);
        end
      end
    end
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("configurable_crc_engine test failed");
      $finish;
    end
  end

  always @(negedge clk) begin : driver
    msg_byte_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
    end else if (in_gap != 0) begin
      in_valid <= 1'b0;
      in_gap--;
    end else if (byte_stream.size() != 0) begin
      nxt = byte_stream.pop_front();
      in_valid <= 1'b1;
      data_byte <= nxt.data;
      last_byte <= nxt.last;
      in_gap = pick_gap(in_idle_pct);
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin : receiver
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap(out_stall_pct);
    end
  end

  task automatic push_byte(input logic [7:0] d, input logic lst);
    msg_byte_t b;
    b.data = d;
    b.last = lst;
    byte_stream.push_back(b);
    bytes_queued++;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (byte_stream.size() != 0 || in_valid || pending_crcs.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] mode, input logic [31:0] p, input logic [31:0] ini,
                           input logic [31:0] xo, input logic [31:0] ri, input logic [31:0] ro);
    write_reg(REG_WIDTH_MODE, mode);
    write_reg(REG_POLY, p);
    write_reg(REG_INIT_VALUE, ini);
    write_reg(REG_XOR_OUT, xo);
    write_reg(REG_REFLECT_IN, ri);
    write_reg(REG_REFLECT_OUT, ro);
  endtask

  initial begin : sequencer
    int phase;
    int quota;
    int len;
    int n;
    int i;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // reset settings: standard reflected CRC-32
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h5A, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hA5, 1'b0);
    wait_drained();
    // restart a message in progress; spare width code acts as 32 bits
    write_reg(REG_WIDTH_MODE, {30'h3FFF_FFFF, WIDTH_MODE_SPARE});
    end_writes();
    push_byte(8'h3C, 1'b0);
    wait_drained();
    // unknown index leaves the running message alone
    write_reg(REG_SPARE_LO, CRC_ONES32);
    end_writes();
    push_byte(8'hC3, 1'b1);
    wait_drained();
    write_all({30'h0, WIDTH_MODE_8}, 32'h0000_0007, CRC_ONES32, 32'h0, 32'hFFFF_FFFE, 32'h0);
    end_writes();
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'h01, 1'b1);
    wait_drained();
    write_all({30'h0, WIDTH_MODE_16}, CRC_ONES32, 32'h0, CRC_ONES32, 32'h1, 32'h0);
    end_writes();
    push_byte(8'h7E, 1'b0);
    push_byte(8'h81, 1'b1);
    push_byte(8'hFF, 1'b1);
    wait_drained();
    write_all({30'h0, WIDTH_MODE_32}, 32'h0, 32'h1234_5678, 32'hAAAA_5555, 32'h0, 32'h1);
    write_reg(REG_SPARE_HI, 32'h0);
    end_writes();
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h55, 1'b1);

    phase = 0;
    while (bytes_queued < TOTAL_BYTES) begin
      wait_drained();
      write_all($urandom, pick_word(), pick_word(), pick_word(), $urandom, $urandom);
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE_LO | 3'($urandom_range(0, 1)), $urandom);
      end_writes();
      case (phase % 4)
        0: begin in_idle_pct = 0; out_stall_pct = 0; end
        1: begin in_idle_pct = 20; out_stall_pct = 20; end
        2: begin in_idle_pct = 50; out_stall_pct = 10; end
        default: begin in_idle_pct = 10; out_stall_pct = 50; end
      endcase
      quota = $urandom_range(80, 200);
      n = 0;
      while (n < quota) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 6);
        for (i = 0; i < len; i++) push_byte(8'($urandom), i == len - 1);
        n += len;
      end
      if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 5);
        for (i = 0; i < len; i++) push_byte(8'($urandom), 1'b0);
      end
      phase++;
    end
    wait_drained();

    if (mismatches == 0) begin
      $display("configurable_crc_engine test passed");
    end else begin
      $display("configurable_crc_engine test failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/cce_pkg.sv
rtl/cce_cfg.sv
rtl/cce_step.sv
rtl/cce_out.sv
rtl/configurable_crc_engine.sv
verif/tb_configurable_crc_engine.sv
